FILE: rtl/lcdnib_pkg.sv
// ----------------------------------------------------------------------------
// lcdnib_pkg
// Shared types and constants for the character LCD nibble port sequencer.
// ----------------------------------------------------------------------------
package lcdnib_pkg;

    localparam int UC_DEPTH  = 43;
    localparam int UC_AW     = 6;

    localparam logic [UC_AW-1:0] UC_INIT = 6'd0;
    localparam logic [UC_AW-1:0] UC_BYTE = 6'd37;
    localparam logic [UC_AW-1:0] UC_LAST = 6'd42;

    localparam logic [1:0] MODE_INIT   = 2'd0;
    localparam logic [1:0] MODE_CMD    = 2'd1;
    localparam logic [1:0] MODE_DATA   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [15:0] STEP_WAIT_US = 16'd1000;
    localparam logic [15:0] INIT_WAIT_US = 16'd36000;

    typedef enum logic [1:0] {
        NS_BLANK = 2'd0,
        NS_CONST = 2'd1,
        NS_HIGH  = 2'd2,
        NS_LOW   = 2'd3
    } t_nib_sel;

    typedef enum logic [1:0] {
        HOLD_NONE = 2'd0,
        HOLD_STEP = 2'd1,
        HOLD_INIT = 2'd2
    } t_hold_sel;

    typedef struct packed {
        t_nib_sel   nib_sel;
        logic [3:0] nib;
        logic       en;
        t_hold_sel  hold_sel;
        logic       last;
    } t_uword;

endpackage

FILE: rtl/char_lcd_nibble_port_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_port_sequencer
// Character LCD (4-bit mode) request to port expander write sequencer.
//
// Input channel (i_valid / o_stall): one request per transaction, i_mode
// selects init (0), command byte (1) or data character (2); mode 3 is
// accepted and dropped. i_char_byte is ignored for init.
// Output channel (o_valid / i_stall): one expander write per transaction,
// with the wait after it in o_hold_us and o_last_write on the final one.
// A byte request gives 6 writes, init gives 37. A microcode step counter
// walks a ROM, one write per cycle unless i_stall holds a full output
// register. The step counter is loaded at acceptance, and each write is
// then registered into the output register from the ROM word it points at.
// Only one request is in flight: o_stall is high while the program runs,
// and the next request can be taken on the cycle after the last write
// is registered. When i_stall is high and the output register is full,
// it holds and the step counter waits. Reset empties the output register
// and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module char_lcd_nibble_port_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_char_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_port_byte,
    output logic [15:0] o_hold_us,
    output logic        o_last_write
);

    logic                          r_busy, n_busy;
    logic [lcdnib_pkg::UC_AW-1:0]  r_pc, n_pc;
    logic                          r_rs, n_rs;
    logic [7:0]                    r_data, n_data;
    logic                          r_out_valid;
    logic [7:0]                    r_port_byte;
    logic [15:0]                   r_hold_us;
    logic                          r_last_write;

    lcdnib_pkg::t_uword uword;
    logic [7:0]         dp_port_byte;
    logic [15:0]        dp_hold_us;
    logic               in_acc;
    logic               step;

    lcdnib_ucode u_ucode (
        .i_addr  (r_pc),
        .o_uword (uword)
    );

    lcdnib_datapath u_datapath (
        .i_uword     (uword),
        .i_data      (r_data),
        .i_rs        (r_rs),
        .o_port_byte (dp_port_byte),
        .o_hold_us   (dp_hold_us)
    );

    assign o_stall = r_busy;
    assign in_acc  = i_valid && !r_busy;
    assign step    = r_busy && (!r_out_valid || !i_stall);

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_rs   = r_rs;
        n_data = r_data;
        if (in_acc) begin
            n_data = i_char_byte;
            n_rs   = (i_mode == lcdnib_pkg::MODE_DATA);
            case (i_mode)
                lcdnib_pkg::MODE_INIT: begin
                    n_busy = 1'b1;
                    n_pc   = lcdnib_pkg::UC_INIT;
                end
                lcdnib_pkg::MODE_CMD, lcdnib_pkg::MODE_DATA: begin
                    n_busy = 1'b1;
                    n_pc   = lcdnib_pkg::UC_BYTE;
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end else if (step) begin
            n_pc = r_pc + 1'b1;
            if (uword.last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= lcdnib_pkg::UC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rs   <= n_rs;
        r_data <= n_data;
        if (step) begin
            r_port_byte  <= dp_port_byte;
            r_hold_us    <= dp_hold_us;
            r_last_write <= uword.last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_port_byte  = r_port_byte;
    assign o_hold_us    = r_hold_us;
    assign o_last_write = r_last_write;

`ifndef SYNTHESIS
    a_pc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pc <= lcdnib_pkg::UC_LAST)
        else $error("step counter ran past the microprogram");

    a_init_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == lcdnib_pkg::MODE_INIT) |=> (r_busy && r_pc == lcdnib_pkg::UC_INIT))
        else $error("init request did not start the init program");

    a_unused_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == lcdnib_pkg::MODE_UNUSED) |=> !r_busy)
        else $error("unused mode started a program");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && uword.last) |=> (!r_busy && o_valid && o_last_write))
        else $error("final write did not release the sequencer");
`endif

endmodule

FILE: rtl/lcdnib_ucode.sv
// ----------------------------------------------------------------------------
// lcdnib_ucode
// Microcode ROM: one control word per port write. Init program at the
// bottom, byte program on top.
// ----------------------------------------------------------------------------
module lcdnib_ucode (
    input  logic [lcdnib_pkg::UC_AW-1:0] i_addr,
    output lcdnib_pkg::t_uword           o_uword
);

    function automatic lcdnib_pkg::t_uword mk(
        input lcdnib_pkg::t_nib_sel  sel,
        input logic [3:0]            nib,
        input logic                  en,
        input lcdnib_pkg::t_hold_sel hold,
        input logic                  last
    );
        lcdnib_pkg::t_uword w;
        w.nib_sel  = sel;
        w.nib      = nib;
        w.en       = en;
        w.hold_sel = hold;
        w.last     = last;
        return w;
    endfunction

    always_comb begin
        case (i_addr)
            6'd0:    o_uword = mk(lcdnib_pkg::NS_BLANK, 4'h0, 1'b0, lcdnib_pkg::HOLD_NONE, 1'b0);
            6'd1:    o_uword = mk(lcdnib_pkg::NS_CONST, 4'h3, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd2:    o_uword = mk(lcdnib_pkg::NS_CONST, 4'h3, 1'b1, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd3:    o_uword = mk(lcdnib_pkg::NS_CONST, 4'h3, 1'b0, lcdnib_pkg::HOLD_INIT, 1'b0);
            6'd4:    o_uword = mk(lcdnib_pkg::NS_CONST, 4'h3, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd5:    o_uword = mk(lcdnib_pkg::NS_CONST, 4'h3, 1'b1, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd6:    o_uword = mk(lcdnib_pkg::NS_CONST, 4'h3, 1'b0, lcdnib_pkg::HOLD_INIT, 1'b0);
            6'd7:    o_uword = mk(lcdnib_pkg::NS_CONST, 4'h3, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd8:    o_uword = mk(lcdnib_pkg::NS_CONST, 4'h3, 1'b1, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd9:    o_uword = mk(lcdnib_pkg::NS_CONST, 4'h3, 1'b0, lcdnib_pkg::HOLD_INIT, 1'b0);
            6'd10:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h2, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd11:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h2, 1'b1, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd12:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h2, 1'b0, lcdnib_pkg::HOLD_INIT, 1'b0);
            // function set 0x28
            6'd13:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h2, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd14:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h2, 1'b1, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd15:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h2, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd16:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h8, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd17:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h8, 1'b1, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd18:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h8, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            // clear 0x01
            6'd19:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h0, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd20:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h0, 1'b1, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd21:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h0, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd22:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h1, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd23:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h1, 1'b1, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd24:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h1, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            // entry mode 0x06
            6'd25:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h0, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd26:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h0, 1'b1, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd27:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h0, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd28:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h6, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd29:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h6, 1'b1, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd30:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h6, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            // display on 0x0C
            6'd31:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h0, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd32:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h0, 1'b1, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd33:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'h0, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd34:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'hC, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd35:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'hC, 1'b1, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd36:   o_uword = mk(lcdnib_pkg::NS_CONST, 4'hC, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b1);
            // byte program
            6'd37:   o_uword = mk(lcdnib_pkg::NS_HIGH,  4'h0, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd38:   o_uword = mk(lcdnib_pkg::NS_HIGH,  4'h0, 1'b1, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd39:   o_uword = mk(lcdnib_pkg::NS_HIGH,  4'h0, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd40:   o_uword = mk(lcdnib_pkg::NS_LOW,   4'h0, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd41:   o_uword = mk(lcdnib_pkg::NS_LOW,   4'h0, 1'b1, lcdnib_pkg::HOLD_STEP, 1'b0);
            6'd42:   o_uword = mk(lcdnib_pkg::NS_LOW,   4'h0, 1'b0, lcdnib_pkg::HOLD_STEP, 1'b1);
            default: o_uword = mk(lcdnib_pkg::NS_BLANK, 4'h0, 1'b0, lcdnib_pkg::HOLD_NONE, 1'b1);
        endcase
    end

endmodule

FILE: rtl/lcdnib_datapath.sv
// ----------------------------------------------------------------------------
// lcdnib_datapath
// Builds the expander byte and wait time from a control word and the
// latched request byte.
// ----------------------------------------------------------------------------
module lcdnib_datapath (
    input  lcdnib_pkg::t_uword i_uword,
    input  logic [7:0]         i_data,
    input  logic               i_rs,
    output logic [7:0]         o_port_byte,
    output logic [15:0]        o_hold_us
);

    logic [3:0] nib;

    always_comb begin
        case (i_uword.nib_sel)
            lcdnib_pkg::NS_HIGH:  nib = i_data[7:4];
            lcdnib_pkg::NS_LOW:   nib = i_data[3:0];
            lcdnib_pkg::NS_CONST: nib = i_uword.nib;
            default:              nib = 4'h0;
        endcase
    end

    always_comb begin
        if (i_uword.nib_sel == lcdnib_pkg::NS_BLANK) begin
            o_port_byte = 8'h00;
        end else begin
            // nibble, backlight, enable, unused, register select
            o_port_byte = {nib, 1'b1, i_uword.en, 1'b0, i_rs};
        end
    end

    always_comb begin
        case (i_uword.hold_sel)
            lcdnib_pkg::HOLD_STEP: o_hold_us = lcdnib_pkg::STEP_WAIT_US;
            lcdnib_pkg::HOLD_INIT: o_hold_us = lcdnib_pkg::INIT_WAIT_US;
            default:               o_hold_us = 16'd0;
        endcase
    end

endmodule
